// ===== rtl/core/convex_hull_graham_scan_assert.svh =====
// Assertion macros shared by the convex hull RTL.
// Expects signals named clk and rst_n in the scope of use; no other dependency.
`ifndef CONVEX_HULL_GRAHAM_SCAN_ASSERT_SVH
`define CONVEX_HULL_GRAHAM_SCAN_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("convex hull assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("convex hull assertion failed");

`endif

// ===== rtl/core/chg_pkg.sv =====
// Shared types and constants of the convex hull block.
// No dependencies; used by chg_turn and convex_hull_graham_scan.
package chg_pkg;

    localparam int CHG_MAX_POINTS = 64;

    // Packed so that x sits in the low half and y in the high half.
    typedef struct packed {
        logic signed [15:0] y;
        logic signed [15:0] x;
    } pt_t;

    typedef struct packed {
        logic done;
        logic neg;
        logic zero;
    } turn_res_t;

    typedef enum logic [1:0] {
        TP_IDLE,
        TP_MUL1,
        TP_MUL2,
        TP_DONE
    } turn_phase_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_ORG_RD,
        ST_ORG_CMP,
        ST_SWAP_RD,
        ST_SWAP_W0,
        ST_SWAP_W1,
        ST_SORT_RD,
        ST_SORT_KEY,
        ST_SORT_CHK,
        ST_SORT_CAND,
        ST_SORT_TURN,
        ST_SORT_PLACE,
        ST_SCAN_LOOP,
        ST_SCAN_P,
        ST_SCAN_CHK,
        ST_SCAN_A,
        ST_SCAN_B,
        ST_SCAN_TURN,
        ST_SCAN_PUSH,
        ST_SCAN_END,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

endpackage

// ===== rtl/core/chg_turn.sv =====
// Sign of the cross product (b - a) x (d - c).
// Depends on chg_pkg; one 17x17 multiplier is shared by both products.
module chg_turn
    import chg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  pt_t       pa,
    input  pt_t       pb,
    input  pt_t       pc,
    input  pt_t       pd,
    output turn_res_t res
);

    turn_phase_t        phase_reg, phase_next;
    logic signed [16:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic signed [33:0] p1_reg, p2_reg;
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] prod;
    logic signed [34:0] diff;

    always_comb
    begin
        if (phase_reg == TP_MUL1)
        begin
            mul_a = dx1_reg;
            mul_b = dy2_reg;
        end
        else
        begin
            mul_a = dy1_reg;
            mul_b = dx2_reg;
        end
        prod = mul_a * mul_b;
        diff = 35'(p1_reg) - 35'(p2_reg);
    end

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            TP_IDLE: if (start) phase_next = TP_MUL1;
            TP_MUL1: phase_next = TP_MUL2;
            TP_MUL2: phase_next = TP_DONE;
            TP_DONE: phase_next = start ? TP_MUL1 : TP_IDLE;
            default: phase_next = TP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= TP_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dx1_reg <= 17'(pb.x) - 17'(pa.x);
            dy1_reg <= 17'(pb.y) - 17'(pa.y);
            dx2_reg <= 17'(pd.x) - 17'(pc.x);
            dy2_reg <= 17'(pd.y) - 17'(pc.y);
        end
        if (phase_reg == TP_MUL1)
            p1_reg <= prod;
        if (phase_reg == TP_MUL2)
            p2_reg <= prod;
    end

    assign res.done = (phase_reg == TP_DONE);
    assign res.neg  = diff[34];
    assign res.zero = (diff == 35'sd0);

endmodule

// ===== rtl/core/convex_hull_graham_scan.sv =====
// Top level of the convex hull block: point store, hull stack and sequencer.
// Depends on chg_pkg, chg_turn and convex_hull_graham_scan_assert.svh.
//
//  Channel | Direction | Transaction
//  s_*     | in        | one point: tdata = px, py; tlast = last_point
//  m_*     | out       | one hull vertex: tdata = hull_x, hull_y; tlast = last_vertex;
//          |           | tuser = overflowed
//
// Points are taken one per cycle while loading. After the marked point the
// sequencer runs an origin search, an insertion sort by compare-and-shift
// steps and the scan with its turn tests, all paced by the shared cross
// product unit and the single read port of each memory. Each vertex is read
// from the stack and held on m_* until taken before the next is read.
// Reset clears the control state only; the memories hold no reset value.
// While the hull is computed or emitted, s_tready is low.
`include "convex_hull_graham_scan_assert.svh"

module convex_hull_graham_scan
    import chg_pkg::*;
#(
    parameter int MAX_POINTS = CHG_MAX_POINTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] px, [31:16] py
    input  logic        s_tlast,   // last_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] hull_x, [31:16] hull_y
    output logic        m_tlast,   // last_vertex
    output logic [0:0]  m_tuser    // [0] overflowed
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 2);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   top_reg, top_next;
    logic [AW-1:0]   j_reg, j_next;
    logic [AW-1:0]   k_reg, k_next;
    logic [AW-1:0]   best_reg, best_next;
    logic            flag_reg, flag_next;
    logic            ovalid_reg, ovalid_next;
    logic            olast_reg, olast_next;
    logic            oovf_reg, oovf_next;
    pt_t             opt_reg, opt_next;
    pt_t             bestpt_reg, bestpt_next;
    pt_t             o_reg, o_next;
    pt_t             key_reg, key_next;
    pt_t             cand_reg, cand_next;
    pt_t             p_reg, p_next;
    pt_t             a_reg, a_next;

    // Point store and hull stack: one write and one registered read each.
    pt_t             ps_mem [MAX_POINTS];
    pt_t             hs_mem [MAX_POINTS];
    pt_t             ps_q, hs_q, ps_wdata, hs_wdata;
    logic            ps_we, hs_we;
    logic [AW-1:0]   ps_waddr, ps_raddr, hs_waddr, hs_raddr;

    logic            turn_start;
    pt_t             t_a, t_b, t_c, t_d;
    turn_res_t       turn_res;

    logic            in_acc, out_acc, room, before_ok, za, zb;
    logic [CW-1:0]   top_m1, top_m2, i_p1;
    pt_t             in_pt;

    chg_turn u_turn (
        .clk   (clk),
        .rst_n (rst_n),
        .start (turn_start),
        .pa    (t_a),
        .pb    (t_b),
        .pc    (t_c),
        .pd    (t_d),
        .res   (turn_res)
    );

    always_ff @(posedge clk)
    begin
        if (ps_we)
            ps_mem[ps_waddr] <= ps_wdata;
        ps_q <= ps_mem[ps_raddr];
        if (hs_we)
            hs_mem[hs_waddr] <= hs_wdata;
        hs_q <= hs_mem[hs_raddr];
    end

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = ovalid_reg && m_tready;
    assign room    = (count_reg < CW'(MAX_POINTS));
    assign top_m1  = top_reg - CW'(1);
    assign top_m2  = top_reg - CW'(2);
    assign i_p1    = i_reg + CW'(1);
    assign in_pt   = pt_t'(s_tdata);

    // Ordering of the key against a candidate around the origin.
    always_comb
    begin
        za = (key_reg == o_reg);
        zb = (cand_reg == o_reg);
        if (za)
            before_ok = !zb;
        else if (zb)
            before_ok = 1'b0;
        else if (!turn_res.zero)
            before_ok = !turn_res.neg;
        else if (key_reg.x != cand_reg.x)
            before_ok = (key_reg.x < cand_reg.x);
        else
            before_ok = (key_reg.y < cand_reg.y);
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        top_next    = top_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        best_next   = best_reg;
        flag_next   = flag_reg;
        ovalid_next = ovalid_reg;
        olast_next  = olast_reg;
        oovf_next   = oovf_reg;
        opt_next    = opt_reg;
        bestpt_next = bestpt_reg;
        o_next      = o_reg;
        key_next    = key_reg;
        cand_next   = cand_reg;
        p_next      = p_reg;
        a_next      = a_reg;
        ps_we       = 1'b0;
        ps_waddr    = '0;
        ps_wdata    = in_pt;
        ps_raddr    = '0;
        hs_we       = 1'b0;
        hs_waddr    = top_reg[AW-1:0];
        hs_wdata    = p_reg;
        hs_raddr    = '0;
        turn_start  = 1'b0;
        t_a         = o_reg;
        t_b         = key_reg;
        t_c         = o_reg;
        t_d         = ps_q;
        s_tready    = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (in_acc)
                begin
                    if (room)
                    begin
                        ps_we      = 1'b1;
                        ps_waddr   = count_reg[AW-1:0];
                        count_next = count_reg + CW'(1);
                    end
                    else
                        flag_next = 1'b1;
                    if (s_tlast)
                    begin
                        n_next     = room ? count_reg + CW'(1) : count_reg;
                        i_next     = '0;
                        top_next   = '0;
                        state_next = ST_ORG_RD;
                    end
                end
            end
            ST_ORG_RD:
            begin
                ps_raddr   = i_reg[AW-1:0];
                state_next = ST_ORG_CMP;
            end
            ST_ORG_CMP:
            begin
                if ((i_reg == '0) || (ps_q.y < bestpt_reg.y) ||
                    ((ps_q.y == bestpt_reg.y) && (ps_q.x < bestpt_reg.x)))
                begin
                    best_next   = i_reg[AW-1:0];
                    bestpt_next = ps_q;
                end
                i_next     = i_p1;
                state_next = (i_p1 < n_reg) ? ST_ORG_RD : ST_SWAP_RD;
            end
            ST_SWAP_RD:
            begin
                ps_raddr   = '0;
                state_next = ST_SWAP_W0;
            end
            ST_SWAP_W0:
            begin
                ps_we      = 1'b1;
                ps_waddr   = best_reg;
                ps_wdata   = ps_q;
                state_next = ST_SWAP_W1;
            end
            ST_SWAP_W1:
            begin
                ps_we      = 1'b1;
                ps_waddr   = '0;
                ps_wdata   = bestpt_reg;
                o_next     = bestpt_reg;
                i_next     = CW'(2);
                state_next = (CW'(2) < n_reg) ? ST_SORT_RD : ST_SCAN_LOOP;
                if (!(CW'(2) < n_reg))
                    i_next = '0;
            end
            ST_SORT_RD:
            begin
                ps_raddr   = i_reg[AW-1:0];
                state_next = ST_SORT_KEY;
            end
            ST_SORT_KEY:
            begin
                key_next   = ps_q;
                j_next     = i_reg[AW-1:0];
                state_next = ST_SORT_CHK;
            end
            ST_SORT_CHK:
            begin
                ps_raddr   = j_reg - AW'(1);
                state_next = (j_reg > AW'(1)) ? ST_SORT_CAND : ST_SORT_PLACE;
            end
            ST_SORT_CAND:
            begin
                cand_next  = ps_q;
                turn_start = 1'b1;
                state_next = ST_SORT_TURN;
            end
            ST_SORT_TURN:
            begin
                if (turn_res.done)
                begin
                    if (before_ok)
                    begin
                        ps_we      = 1'b1;
                        ps_waddr   = j_reg;
                        ps_wdata   = cand_reg;
                        j_next     = j_reg - AW'(1);
                        state_next = ST_SORT_CHK;
                    end
                    else
                        state_next = ST_SORT_PLACE;
                end
            end
            ST_SORT_PLACE:
            begin
                ps_we    = 1'b1;
                ps_waddr = j_reg;
                ps_wdata = key_reg;
                if (i_p1 < n_reg)
                begin
                    i_next     = i_p1;
                    state_next = ST_SORT_RD;
                end
                else
                begin
                    i_next     = '0;
                    state_next = ST_SCAN_LOOP;
                end
            end
            ST_SCAN_LOOP:
            begin
                ps_raddr = (i_reg < n_reg) ? i_reg[AW-1:0] : '0;
                if ((i_reg <= n_reg) && (top_reg < n_reg))
                    state_next = ST_SCAN_P;
                else
                    state_next = ST_SCAN_END;
            end
            ST_SCAN_P:
            begin
                p_next     = ps_q;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                hs_raddr   = top_m2[AW-1:0];
                state_next = (top_reg >= CW'(2)) ? ST_SCAN_A : ST_SCAN_PUSH;
            end
            ST_SCAN_A:
            begin
                a_next     = hs_q;
                hs_raddr   = top_m1[AW-1:0];
                state_next = ST_SCAN_B;
            end
            ST_SCAN_B:
            begin
                turn_start = 1'b1;
                t_a        = a_reg;
                t_b        = hs_q;
                t_c        = a_reg;
                t_d        = p_reg;
                state_next = ST_SCAN_TURN;
            end
            ST_SCAN_TURN:
            begin
                if (turn_res.done)
                begin
                    if (turn_res.neg)
                    begin
                        top_next   = top_m1;
                        state_next = ST_SCAN_CHK;
                    end
                    else
                        state_next = ST_SCAN_PUSH;
                end
            end
            ST_SCAN_PUSH:
            begin
                hs_we      = 1'b1;
                top_next   = top_reg + CW'(1);
                i_next     = i_p1;
                state_next = ST_SCAN_LOOP;
            end
            ST_SCAN_END:
            begin
                // The closing copy of the origin is dropped when it was pushed.
                if ((i_reg == n_reg + CW'(1)) && (top_reg > CW'(1)))
                    top_next = top_m1;
                k_next     = '0;
                state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                hs_raddr   = k_reg;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                opt_next    = hs_q;
                olast_next  = (CW'(k_reg) == top_m1);
                oovf_next   = flag_reg;
                ovalid_next = 1'b1;
                state_next  = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (out_acc)
                begin
                    ovalid_next = 1'b0;
                    if (olast_reg)
                    begin
                        count_next = '0;
                        flag_next  = 1'b0;
                        top_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            top_reg    <= '0;
            flag_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            top_reg    <= top_next;
            flag_reg   <= flag_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        best_reg   <= best_next;
        olast_reg  <= olast_next;
        oovf_reg   <= oovf_next;
        opt_reg    <= opt_next;
        bestpt_reg <= bestpt_next;
        o_reg      <= o_next;
        key_reg    <= key_next;
        cand_reg   <= cand_next;
        p_reg      <= p_next;
        a_reg      <= a_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = opt_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = oovf_reg;

    // Loading and emitting never overlap.
    `CHG_ASSERT_IMP(a_no_load_emit, m_tvalid, !s_tready)
    // The point count never passes the capacity.
    `CHG_ASSERT_IMP(a_count_cap, 1'b1, count_reg <= CW'(MAX_POINTS))
    // The stack never holds more entries than the set has points.
    `CHG_ASSERT_IMP(a_top_bound, state_reg != ST_LOAD, top_reg <= n_reg)
    // The last vertex taken returns the block to loading.
    `CHG_ASSERT_NXT(a_emit_done, m_tvalid && m_tready && m_tlast, state_reg == ST_LOAD)

endmodule
